### rtl/apr_pkg.sv
// Shared types and constants for the aging page replacement unit.
package apr_pkg;

   localparam int PAGE_SHIFT_W     = 4;
   localparam int PAGE_SHIFT_RESET = 2;
   localparam int FRAME_FIELD_W    = 3;
   localparam int EVICT_PAGE_W     = 16;

   // Op field codes of a request word
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Command broadcast from the controller to every frame cell
   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_TICK,
      CMD_SET_REF,
      CMD_FILL
   } cmd_type;

   // Status of the search token that walks down the cell chain
   typedef struct packed {
      logic valid;
      logic hit;
      logic has_empty;
      logic has_min;
   } scan_flags_type;

endpackage

### rtl/apr_req_if.sv
// Request channel: op and byte address.
interface apr_req_if #(
   parameter int ADDR_BITS = 16
);
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [ADDR_BITS-1:0] address;

   modport source (output valid, output op, output address, input ready);
   modport sink   (input valid, input op, input address, output ready);
endinterface

### rtl/apr_rsp_if.sv
// Response channel: hit, frame and eviction report.
interface apr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              hit;
   logic [apr_pkg::FRAME_FIELD_W-1:0] frame;
   logic                              evicted_valid;
   logic [apr_pkg::EVICT_PAGE_W-1:0]  evicted_page;

   modport source (output valid, output hit, output frame, output evicted_valid,
                   output evicted_page, input ready);
   modport sink   (input valid, input hit, input frame, input evicted_valid,
                   input evicted_page, output ready);
endinterface

### rtl/apr_cell.sv
// One frame cell: frame state plus one stage of the search chain.
module apr_cell #(
   parameter int FRAMES    = 8,
   parameter int AGE_BITS  = 8,
   parameter int ADDR_BITS = 16,
   parameter int IDX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  apr_pkg::cmd_type              cmd,
   input  logic                          sel,
   input  logic [ADDR_BITS-1:0]          page,
   input  apr_pkg::scan_flags_type       flags_prev,
   input  logic [$clog2(FRAMES)-1:0]     hit_idx_prev,
   input  logic [$clog2(FRAMES)-1:0]     empty_idx_prev,
   input  logic [AGE_BITS-1:0]           min_age_prev,
   input  logic [$clog2(FRAMES)-1:0]     min_idx_prev,
   input  logic [ADDR_BITS-1:0]          min_page_prev,
   output apr_pkg::scan_flags_type       flags_next,
   output logic [$clog2(FRAMES)-1:0]     hit_idx_next,
   output logic [$clog2(FRAMES)-1:0]     empty_idx_next,
   output logic [AGE_BITS-1:0]           min_age_next,
   output logic [$clog2(FRAMES)-1:0]     min_idx_next,
   output logic [ADDR_BITS-1:0]          min_page_next
);
   localparam int IDX_W = $clog2(FRAMES);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic                 used_ff;
   logic                 ref_ff;
   logic [AGE_BITS-1:0]  age_ff;
   logic [ADDR_BITS-1:0] page_ff;

   apr_pkg::scan_flags_type flags_ff, flags_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]     empty_idx_ff, empty_idx_in;
   logic [AGE_BITS-1:0]  min_age_ff, min_age_in;
   logic [IDX_W-1:0]     min_idx_ff, min_idx_in;
   logic [ADDR_BITS-1:0] min_page_ff, min_page_in;

   logic match;

   assign match = used_ff && (page_ff == page);

   // Fold this frame into the token: first hit wins, last empty wins,
   // strictly smaller age wins among used frames.
   always_comb begin
      flags_in     = flags_prev;
      hit_idx_in   = hit_idx_prev;
      empty_idx_in = empty_idx_prev;
      min_age_in   = min_age_prev;
      min_idx_in   = min_idx_prev;
      min_page_in  = min_page_prev;
      if (!flags_prev.hit && match) begin
         flags_in.hit = 1'b1;
         hit_idx_in   = MY_IDX;
      end
      if (!used_ff) begin
         flags_in.has_empty = 1'b1;
         empty_idx_in       = MY_IDX;
      end else if (!flags_prev.has_min || (age_ff < min_age_prev)) begin
         flags_in.has_min = 1'b1;
         min_age_in       = age_ff;
         min_idx_in       = MY_IDX;
         min_page_in      = page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      hit_idx_ff   <= hit_idx_in;
      empty_idx_ff <= empty_idx_in;
      min_age_ff   <= min_age_in;
      min_idx_ff   <= min_idx_in;
      min_page_ff  <= min_page_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         ref_ff  <= 1'b0;
         age_ff  <= '0;
      end else begin
         case (cmd)
            apr_pkg::CMD_TICK: begin
               age_ff <= {ref_ff, age_ff[AGE_BITS-1:1]};
               ref_ff <= 1'b0;
            end
            apr_pkg::CMD_SET_REF: begin
               if (sel) ref_ff <= 1'b1;
            end
            apr_pkg::CMD_FILL: begin
               if (sel) begin
                  used_ff <= 1'b1;
                  ref_ff  <= 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (cmd == apr_pkg::CMD_FILL && sel) page_ff <= page;
   end

   assign flags_next     = flags_ff;
   assign hit_idx_next   = hit_idx_ff;
   assign empty_idx_next = empty_idx_ff;
   assign min_age_next   = min_age_ff;
   assign min_idx_next   = min_idx_ff;
   assign min_page_next  = min_page_ff;

endmodule

### rtl/aging_page_replacement_unit.sv
// Top level: controller, page shift register and the chain of frame cells.
//
//   port      dir    handshake      word
//   req_chan  in     valid/ready    op, address
//   rsp_chan  out    valid/ready    hit, frame, evicted_valid, evicted_page
//   csr_*     in     write enable   page_shift (4 bits)
//
// An access sends a search token down the chain of frame cells: the search
// token crosses one frame cell per cycle. A tick skips the search.
// One word is in work at a time; a new request is taken as soon as the
// previous one has loaded the response register, even if that word waits.
// Synchronous reset empties all frames and clears ages and reference bits.
module aging_page_replacement_unit #(
   parameter int FRAMES    = 8,
   parameter int AGE_BITS  = 8,
   parameter int ADDR_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [apr_pkg::PAGE_SHIFT_W-1:0]  csr_write_data,
   apr_req_if.sink                           req_chan,
   apr_rsp_if.source                         rsp_chan
);
   localparam int IDX_W = $clog2(FRAMES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;

   logic [apr_pkg::PAGE_SHIFT_W-1:0] page_shift_ff;
   logic                 op_ff;
   logic [ADDR_BITS-1:0] page_ff;
   logic                 start_ff;
   logic                 hit_ff;
   logic                 evict_valid_ff;
   logic [ADDR_BITS-1:0] evict_page_ff;
   logic [IDX_W-1:0]     victim_ff;

   logic                                rsp_valid_ff;
   logic                                rsp_hit_ff;
   logic [apr_pkg::FRAME_FIELD_W-1:0]   rsp_frame_ff;
   logic                                rsp_evicted_valid_ff;
   logic [apr_pkg::EVICT_PAGE_W-1:0]    rsp_evicted_page_ff;

   logic                  accept;
   logic                  out_free;
   logic                  finish;
   apr_pkg::cmd_type      cmd;
   logic [FRAMES-1:0]     sel;
   logic [IDX_W+2:0]      victim_pad;
   logic [ADDR_BITS+15:0] evict_pad;

   apr_pkg::scan_flags_type flags_chain [FRAMES+1];
   logic [IDX_W-1:0]        hit_idx_chain [FRAMES+1];
   logic [IDX_W-1:0]        empty_idx_chain [FRAMES+1];
   logic [AGE_BITS-1:0]     min_age_chain [FRAMES+1];
   logic [IDX_W-1:0]        min_idx_chain [FRAMES+1];
   logic [ADDR_BITS-1:0]    min_page_chain [FRAMES+1];

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish   = (state_ff == ST_FINISH) && out_free;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Token head entering cell 0
   always_comb begin
      flags_chain[0]       = '0;
      flags_chain[0].valid = start_ff;
   end
   assign hit_idx_chain[0]   = '0;
   assign empty_idx_chain[0] = '0;
   assign min_age_chain[0]   = '0;
   assign min_idx_chain[0]   = '0;
   assign min_page_chain[0]  = '0;

   always_comb begin
      cmd = apr_pkg::CMD_NONE;
      if (finish) begin
         if (op_ff == apr_pkg::OP_TICK) cmd = apr_pkg::CMD_TICK;
         else if (hit_ff)               cmd = apr_pkg::CMD_SET_REF;
         else                           cmd = apr_pkg::CMD_FILL;
      end
   end

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      assign sel[i] = (victim_ff == IDX_W'(i));

      apr_cell #(
         .FRAMES    (FRAMES),
         .AGE_BITS  (AGE_BITS),
         .ADDR_BITS (ADDR_BITS),
         .IDX       (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cmd),
         .sel            (sel[i]),
         .page           (page_ff),
         .flags_prev     (flags_chain[i]),
         .hit_idx_prev   (hit_idx_chain[i]),
         .empty_idx_prev (empty_idx_chain[i]),
         .min_age_prev   (min_age_chain[i]),
         .min_idx_prev   (min_idx_chain[i]),
         .min_page_prev  (min_page_chain[i]),
         .flags_next     (flags_chain[i+1]),
         .hit_idx_next   (hit_idx_chain[i+1]),
         .empty_idx_next (empty_idx_chain[i+1]),
         .min_age_next   (min_age_chain[i+1]),
         .min_idx_next   (min_idx_chain[i+1]),
         .min_page_next  (min_page_chain[i+1])
      );
   end

   assign victim_pad = {3'b000, victim_ff};
   assign evict_pad  = {16'h0000, evict_page_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= apr_pkg::PAGE_SHIFT_W'(apr_pkg::PAGE_SHIFT_RESET);
      end else if (csr_write_enable) begin
         page_shift_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= accept && (req_chan.op == apr_pkg::OP_ACCESS);
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff          <= req_chan.op;
                  page_ff        <= req_chan.address >> page_shift_ff;
                  hit_ff         <= 1'b0;
                  evict_valid_ff <= 1'b0;
                  evict_page_ff  <= '0;
                  victim_ff      <= '0;
                  if (req_chan.op == apr_pkg::OP_TICK) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (flags_chain[FRAMES].valid) begin
                  if (flags_chain[FRAMES].hit) begin
                     hit_ff    <= 1'b1;
                     victim_ff <= hit_idx_chain[FRAMES];
                  end else if (flags_chain[FRAMES].has_empty) begin
                     victim_ff <= empty_idx_chain[FRAMES];
                  end else begin
                     victim_ff      <= min_idx_chain[FRAMES];
                     evict_valid_ff <= 1'b1;
                     evict_page_ff  <= min_page_chain[FRAMES];
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_hit_ff           <= hit_ff;
                  rsp_frame_ff         <= victim_pad[2:0];
                  rsp_evicted_valid_ff <= evict_valid_ff;
                  rsp_evicted_page_ff  <= evict_pad[15:0];
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.frame         = rsp_frame_ff;
   assign rsp_chan.evicted_valid = rsp_evicted_valid_ff;
   assign rsp_chan.evicted_page  = rsp_evicted_page_ff;

endmodule

### test/tb_top.sv
// Self-checking bench for the aging page replacement unit.
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAMES       = 8;
   localparam int AGE_BITS     = 8;
   localparam int ADDR_BITS    = 16;
   localparam int DRAIN_CYCLES = FRAMES + 8;
   localparam int HOLD_CYCLES  = 150;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int NUM_PHASES   = 9;
   localparam int PHASE_WORDS  = 200;
   localparam int SHIFT_W      = apr_pkg::PAGE_SHIFT_W;
   localparam int FRAME_W      = apr_pkg::FRAME_FIELD_W;
   localparam int EVICT_W      = apr_pkg::EVICT_PAGE_W;

   typedef struct packed {
      logic                 op;
      logic [ADDR_BITS-1:0] address;
   } access_word_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
      logic               evicted_valid;
      logic [EVICT_W-1:0] evicted_page;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [SHIFT_W-1:0] csr_write_data;

   apr_req_if #(.ADDR_BITS(ADDR_BITS)) req_bus ();
   apr_rsp_if rsp_bus ();

   aging_page_replacement_unit #(
      .FRAMES   (FRAMES),
      .AGE_BITS (AGE_BITS),
      .ADDR_BITS(ADDR_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_chan        (req_bus),
      .rsp_chan        (rsp_bus)
   );

   // frame table mirror
   bit                   slot_used [FRAMES] = '{default: 1'b0};
   logic [ADDR_BITS-1:0] slot_page [FRAMES] = '{default: '0};
   bit                   slot_ref  [FRAMES] = '{default: 1'b0};
   logic [AGE_BITS-1:0]  slot_age  [FRAMES] = '{default: '0};
   logic [SHIFT_W-1:0]   page_shift_model = SHIFT_W'(apr_pkg::PAGE_SHIFT_RESET);

   access_word_type  pending_words[$];
   frame_result_type predicted_outcomes[$];

   int issued_count   = 0;
   int accepted_count = 0;
   int tick_count     = 0;
   int hit_count      = 0;
   int evict_count    = 0;
   int result_count   = 0;
   int error_count    = 0;
   int shift_writes   = 0;
   int cycle_count    = 0;

   int req_idle_pct = 38;
   int rsp_idle_pct = 38;
   int hold_token   = 0;
   int hold_seen    = 0;
   int hold_left    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one word to the mirror and returns what the unit must answer.
   function automatic frame_result_type resolve_access(input logic op,
                                                       input logic [ADDR_BITS-1:0] addr);
      frame_result_type     r;
      logic [ADDR_BITS-1:0] page;
      int                   victim;
      int                   empty_idx;
      int                   oldest;
      r         = '0;
      empty_idx = -1;
      oldest    = 0;
      if (op == apr_pkg::OP_TICK) begin
         for (int i = 0; i < FRAMES; i++) begin
            slot_age[i] = {slot_ref[i], slot_age[i][AGE_BITS-1:1]};
            slot_ref[i] = 1'b0;
         end
         return r;
      end
      page = addr >> page_shift_model;
      for (int i = 0; i < FRAMES; i++) begin
         if (slot_used[i] && slot_page[i] == page) begin
            slot_ref[i] = 1'b1;
            r.hit       = 1'b1;
            r.frame     = FRAME_W'(i);
            return r;
         end
      end
      // highest empty frame wins; otherwise lowest index of the smallest age
      for (int i = 0; i < FRAMES; i++) begin
         if (!slot_used[i]) empty_idx = i;
         else if (slot_age[i] < slot_age[oldest]) oldest = i;
      end
      victim = (empty_idx >= 0) ? empty_idx : oldest;
      if (slot_used[victim]) begin
         r.evicted_valid = 1'b1;
         r.evicted_page  = EVICT_W'(slot_page[victim]);
      end
      slot_used[victim] = 1'b1;
      slot_page[victim] = page;
      slot_ref[victim]  = 1'b1;
      r.frame           = FRAME_W'(victim);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want,
               cycle_count);
   endtask

   task automatic queue_word(input logic op, input logic [ADDR_BITS-1:0] addr);
      access_word_type w;
      w.op      = op;
      w.address = addr;
      pending_words.push_back(w);
   endtask

   // Sender holds back until every word has been answered, plus a margin.
   task automatic drain_all();
      while (pending_words.size() > 0 || issued_count != accepted_count ||
             predicted_outcomes.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_page_shift(input logic [SHIFT_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      page_shift_model = value;
      shift_writes++;
   endtask

   // Mostly accesses to a small page pool so hits, fills and evictions all occur.
   task automatic run_phase(input logic [SHIFT_W-1:0] shift, input int count);
      logic [ADDR_BITS-1:0] pool [12];
      logic [ADDR_BITS-1:0] top_page;
      access_word_type      w;
      int                   roll;
      top_page = {ADDR_BITS{1'b1}} >> shift;
      foreach (pool[k]) pool[k] = ADDR_BITS'($urandom_range(0, top_page));
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         w.op = (roll < 15) ? apr_pkg::OP_TICK : apr_pkg::OP_ACCESS;
         if (roll >= 90 || w.op == apr_pkg::OP_TICK)
            w.address = ADDR_BITS'($urandom);
         else
            w.address = ADDR_BITS'((32'(pool[$urandom_range(11)]) << shift) |
                                   ($urandom & ((32'd1 << shift) - 32'd1)));
         pending_words.push_back(w);
         if (n == count / 2) drain_all();
      end
   endtask

   // Driver: one nonblocking update of valid per falling edge.
   always @(negedge clock) begin
      access_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (issued_count == accepted_count) begin
         if (pending_words.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            w = pending_words.pop_front();
            req_bus.valid   <= 1'b1;
            req_bus.op      <= w.op;
            req_bus.address <= w.address;
            issued_count++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver backpressure, with an occasional long hold-off.
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Request acceptance feeds the predictor.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         predicted_outcomes.push_back(resolve_access(req_bus.op, req_bus.address));
         accepted_count++;
         if (req_bus.op == apr_pkg::OP_TICK) tick_count++;
      end
   end

   // Response checker.
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.hit           = rsp_bus.hit;
         got.frame         = rsp_bus.frame;
         got.evicted_valid = rsp_bus.evicted_valid;
         got.evicted_page  = rsp_bus.evicted_page;
         result_count++;
         if (predicted_outcomes.size() == 0) begin
            report_mismatch("response word with nothing outstanding", 32'(got), 32'd0);
         end else begin
            want = predicted_outcomes.pop_front();
            if (got.hit !== want.hit)
               report_mismatch("hit", 32'(got.hit), 32'(want.hit));
            if (got.frame !== want.frame)
               report_mismatch("frame", 32'(got.frame), 32'(want.frame));
            if (got.evicted_valid !== want.evicted_valid)
               report_mismatch("evicted_valid", 32'(got.evicted_valid),
                               32'(want.evicted_valid));
            if (got.evicted_page !== want.evicted_page)
               report_mismatch("evicted_page", 32'(got.evicted_page),
                               32'(want.evicted_page));
            if (want.hit) hit_count++;
            if (want.evicted_valid) evict_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still outstanding", cycle_count,
                  predicted_outcomes.size());
         $display("aging_page_replacement_unit verification failed");
         $finish;
      end
   end

   initial begin
      logic [SHIFT_W-1:0] shift_plan [NUM_PHASES];
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.op       = apr_pkg::OP_ACCESS;
      req_bus.address  = '0;
      rsp_bus.ready    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: fill every frame from the top, hits, ticks, aged eviction.
      queue_word(apr_pkg::OP_ACCESS, 16'h0000);
      queue_word(apr_pkg::OP_ACCESS, 16'h0003);
      queue_word(apr_pkg::OP_ACCESS, 16'hFFFF);
      for (int k = 1; k <= 6; k++) queue_word(apr_pkg::OP_ACCESS, ADDR_BITS'(4 * k));
      queue_word(apr_pkg::OP_ACCESS, 16'h0020);   // all full, equal ages: lowest frame goes
      queue_word(apr_pkg::OP_TICK,   16'hFFFF);
      queue_word(apr_pkg::OP_ACCESS, 16'h0008);
      queue_word(apr_pkg::OP_TICK,   16'h0000);
      queue_word(apr_pkg::OP_ACCESS, 16'h0190);
      queue_word(apr_pkg::OP_ACCESS, 16'hFFFC);
      queue_word(apr_pkg::OP_ACCESS, 16'h0200);
      queue_word(apr_pkg::OP_TICK,   16'h5A5A);
      queue_word(apr_pkg::OP_TICK,   16'hA5A5);
      queue_word(apr_pkg::OP_ACCESS, 16'h0004);
      queue_word(apr_pkg::OP_ACCESS, 16'h8000);
      drain_all();

      shift_plan = '{4'd2, 4'd0, 4'd15, 4'd7, 4'd12, 4'd1, 4'd0, 4'd15, 4'd2};
      shift_plan[6] = SHIFT_W'($urandom_range(3, 14));

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) write_page_shift(shift_plan[p]);
         if (p == 4) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         run_phase(shift_plan[p], PHASE_WORDS);
         if (p == 2 || p == 6) begin
            // receiver goes quiet while requests keep coming
            repeat (20) @(posedge clock);
            hold_token++;
         end
         drain_all();
         req_idle_pct = 38;
         rsp_idle_pct = 38;
      end

      $display("Covered %0d words: %0d ticks, %0d hits, %0d evictions.",
               accepted_count, tick_count, hit_count, evict_count);
      $display("Page shift rewritten %0d times incl. 0 and 15; %0d responses checked.",
               shift_writes, result_count);
      if (error_count == 0) begin
         $display("aging_page_replacement_unit verification clean");
      end else begin
         $display("aging_page_replacement_unit verification failed");
      end
      $finish;
   end

endmodule
